// ===== src/slt_pkg.sv =====
`default_nettype none
package slt_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_REMOVE = 2'd3
  } slt_cmd_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_EMPTY   = 2'd2,
    STS_MISSING = 2'd3
  } slt_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } slt_state_e;

  typedef struct packed {
    slt_cmd_e           cmd;
    logic signed [31:0] key;
  } slt_req_t;

  typedef struct packed {
    slt_status_e status;
    logic [2:0]  position;
    logic [3:0]  fill_count;
  } slt_rsp_t;

  typedef struct packed {
    logic        latch;
    logic        clear_cnt;
    logic        ins;
    logic        idx_clr;
    logic        idx_inc;
    logic        rd_scan;
    logic        rd_next;
    logic        wr_shift;
    logic        dec_cnt;
    logic        set_result;
    logic        use_idx;
    slt_status_e status;
  } slt_dp_cmd_t;

  typedef struct packed {
    slt_cmd_e cmd;
    logic     empty;
    logic     full;
    logic     match;
    logic     last;
  } slt_dp_sts_t;

endpackage
`default_nettype wire

// ===== src/slt_dp.sv =====
`default_nettype none
module slt_dp import slt_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  slt_req_t    req_i,
  input  slt_dp_cmd_t cmd_i,
  output slt_dp_sts_t sts_o,
  output slt_rsp_t    rsp_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rdata_q;
  slt_cmd_e      cmd_q;
  logic [31:0]   key_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] idx_nx;
  slt_status_e   status_q;
  logic [2:0]    pos_q;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          wr_en;

  assign idx_nx  = idx_q + CW'(1);
  assign rd_addr = cmd_i.rd_next ? idx_nx[IW-1:0] : idx_q[IW-1:0];
  assign wr_en   = cmd_i.ins || cmd_i.wr_shift;
  assign wr_addr = cmd_i.ins ? count_q[IW-1:0] : idx_q[IW-1:0];
  assign wr_data = cmd_i.ins ? key_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_scan || cmd_i.rd_next) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= req_i.cmd;
      key_q <= req_i.key;
    end
    if (cmd_i.set_result) begin
      status_q <= cmd_i.status;
      pos_q    <= cmd_i.use_idx ? 3'(idx_q) : 3'd0;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear_cnt) begin
      count_d = '0;
    end else if (cmd_i.ins) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.dec_cnt) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  assign sts_o.cmd   = cmd_q;
  assign sts_o.empty = (count_q == '0);
  assign sts_o.full  = (count_q == CW'(CAPACITY));
  assign sts_o.match = (rdata_q == key_q);
  assign sts_o.last  = (idx_nx == count_q);

  assign rsp_o.status     = status_q;
  assign rsp_o.position   = pos_q;
  assign rsp_o.fill_count = 4'(count_q);

endmodule
`default_nettype wire

// ===== src/slt_ctrl.sv =====
`default_nettype none
module slt_ctrl import slt_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          start_i,
  input  slt_dp_sts_t  sts_i,
  output slt_dp_cmd_t  cmd_o,
  output logic         busy_o,
  output logic         done_o
);

  slt_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if ((sts_i.cmd inside {CMD_SEARCH, CMD_REMOVE}) && !sts_i.empty) begin
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN_RD: state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (sts_i.match) begin
          state_d = (sts_i.cmd == CMD_REMOVE) ? ST_SHIFT_RD : ST_DONE;
        end else if (sts_i.last) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: state_d = sts_i.last ? ST_DONE : ST_SHIFT_WR;
      ST_SHIFT_WR: state_d = ST_SHIFT_RD;
      ST_DONE:     state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    cmd_o.status = STS_OK;
    busy_o = (state_q != ST_IDLE);
    done_o = 1'b0;
    case (state_q)
      ST_IDLE: cmd_o.latch = start_i;
      ST_DISPATCH: begin
        case (sts_i.cmd)
          CMD_CLEAR: begin
            cmd_o.clear_cnt  = 1'b1;
            cmd_o.set_result = 1'b1;
          end
          CMD_INSERT: begin
            cmd_o.set_result = 1'b1;
            if (sts_i.full) begin
              cmd_o.status = STS_FULL;
            end else begin
              cmd_o.ins = 1'b1;
            end
          end
          default: begin
            if (sts_i.empty) begin
              cmd_o.set_result = 1'b1;
              cmd_o.status     = STS_EMPTY;
            end else begin
              cmd_o.idx_clr = 1'b1;
            end
          end
        endcase
      end
      ST_SCAN_RD: cmd_o.rd_scan = 1'b1;
      ST_SCAN_CMP: begin
        if (sts_i.match) begin
          cmd_o.set_result = 1'b1;
          cmd_o.use_idx    = 1'b1;
        end else if (sts_i.last) begin
          cmd_o.set_result = 1'b1;
          cmd_o.status     = STS_MISSING;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_SHIFT_RD: begin
        if (sts_i.last) begin
          cmd_o.dec_cnt = 1'b1;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      ST_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
      end
      ST_DONE: done_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/sequential_list_table_top.sv =====
// Clear and insert are resolved in the dispatch state, as are search and remove on an empty
// list. Otherwise search reads and compares the entries in order from position 0 until a hit or
// the last entry; remove then shifts each later entry down, one entry per read/write pair.
// One command at a time: busy stays high until the strobe cycle ends, so the next
// command is accepted in the cycle after done_o. The receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the list and returns the controller to idle.
`default_nettype none
module sequential_list_table_top import slt_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      start,
  output logic     busy,
  input  slt_req_t req_i,
  output logic     done_o,
  output slt_rsp_t rsp_o
);

  slt_dp_cmd_t dp_cmd;
  slt_dp_sts_t dp_sts;

  slt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (dp_sts),
    .cmd_o   (dp_cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  slt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (dp_cmd),
    .sts_o  (dp_sts),
    .rsp_o  (rsp_o)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import slt_pkg::*;

  localparam int CAPACITY     = 8;
  localparam int NUM_RANDOM   = 930;
  localparam int DRAIN_CYCLES = 48;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    slt_req_t req;
    bit       typed;
    slt_rsp_t rsp;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  logic     done_o;
  slt_req_t req_i;
  slt_rsp_t rsp_o;

  logic [31:0] list_keys [CAPACITY];
  int unsigned list_count;
  slt_rsp_t    pending_rsp [$];
  dir_row_t    dir_rows [$];
  int          mismatches;
  int          results_seen;
  int          cmd_seen [4];
  int          status_seen [4];
  bit          no_idle;

  sequential_list_table_top #(.CAPACITY(CAPACITY)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  function automatic slt_rsp_t list_apply(slt_req_t r);
    slt_rsp_t o;
    int       p;
    int       i;
    o.status   = STS_OK;
    o.position = '0;
    p          = -1;
    case (r.cmd)
      CMD_CLEAR: list_count = 0;
      CMD_INSERT: begin
        if (list_count >= CAPACITY) begin
          o.status = STS_FULL;
        end else begin
          list_keys[list_count] = r.key;
          list_count++;
        end
      end
      default: begin
        if (list_count == 0) begin
          o.status = STS_EMPTY;
        end else begin
          for (i = 0; i < list_count; i++)
            if (p < 0 && list_keys[i] == 32'(r.key)) p = i;
          if (p < 0) begin
            o.status = STS_MISSING;
          end else begin
            o.position = p[2:0];
            if (r.cmd == CMD_REMOVE) begin
              for (i = p; i + 1 < list_count; i++) list_keys[i] = list_keys[i + 1];
              list_count--;
            end
          end
        end
      end
    endcase
    o.fill_count = list_count[3:0];
    return o;
  endfunction

  function automatic dir_row_t mk_row(slt_cmd_e c, logic [31:0] k, bit typed,
                                      slt_status_e s, int pos, int cnt);
    dir_row_t row;
    row.req.cmd        = c;
    row.req.key        = k;
    row.typed          = typed;
    row.rsp.status     = s;
    row.rsp.position   = pos[2:0];
    row.rsp.fill_count = cnt[3:0];
    return row;
  endfunction

  task automatic note_fail(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  task automatic issue(slt_req_t r, bit typed, slt_rsp_t want);
    int       gap;
    slt_rsp_t got;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    got = list_apply(r);
    pending_rsp.push_back(typed ? want : got);
    cmd_seen[r.cmd]++;
  endtask

  always @(posedge clk_i) begin : rsp_monitor
    slt_rsp_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      status_seen[rsp_o.status]++;
      if (pending_rsp.size() == 0) begin
        note_fail($sformatf("unexpected transaction status=%0d pos=%0d cnt=%0d",
                            rsp_o.status, rsp_o.position, rsp_o.fill_count));
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.status !== want.status || rsp_o.position !== want.position ||
            rsp_o.fill_count !== want.fill_count)
          note_fail($sformatf("mismatch: exp status=%0d pos=%0d cnt=%0d, got %0d %0d %0d",
                              want.status, want.position, want.fill_count,
                              rsp_o.status, rsp_o.position, rsp_o.fill_count));
      end
    end
  end

  initial begin : stimulus
    slt_req_t    r;
    slt_rsp_t    none;
    int          pick;
    logic [31:0] k;
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_i      = '0;
    list_count = 0;
    no_idle    = 1'b0;
    none       = '0;
    foreach (list_keys[i]) list_keys[i] = '0;

    dir_rows.push_back(mk_row(CMD_SEARCH, 32'h0000_0000, 1, STS_EMPTY, 0, 0));
    dir_rows.push_back(mk_row(CMD_REMOVE, 32'hFFFF_FFFF, 1, STS_EMPTY, 0, 0));
    dir_rows.push_back(mk_row(CMD_INSERT, 32'h8000_0000, 1, STS_OK, 0, 1));
    dir_rows.push_back(mk_row(CMD_INSERT, 32'h7FFF_FFFF, 1, STS_OK, 0, 2));
    dir_rows.push_back(mk_row(CMD_INSERT, 32'h0000_0000, 1, STS_OK, 0, 3));
    dir_rows.push_back(mk_row(CMD_INSERT, 32'hFFFF_FFFF, 1, STS_OK, 0, 4));
    dir_rows.push_back(mk_row(CMD_INSERT, 32'h7FFF_FFFF, 1, STS_OK, 0, 5));
    dir_rows.push_back(mk_row(CMD_INSERT, 32'h0000_0005, 1, STS_OK, 0, 6));
    dir_rows.push_back(mk_row(CMD_INSERT, 32'h8000_0000, 1, STS_OK, 0, 7));
    dir_rows.push_back(mk_row(CMD_INSERT, 32'h5555_5555, 1, STS_OK, 0, 8));
    dir_rows.push_back(mk_row(CMD_INSERT, 32'h0000_0001, 1, STS_FULL, 0, 8));
    dir_rows.push_back(mk_row(CMD_SEARCH, 32'h7FFF_FFFF, 1, STS_OK, 1, 8));
    dir_rows.push_back(mk_row(CMD_SEARCH, 32'h5555_5555, 1, STS_OK, 7, 8));
    dir_rows.push_back(mk_row(CMD_SEARCH, 32'h8000_0000, 1, STS_OK, 0, 8));
    dir_rows.push_back(mk_row(CMD_SEARCH, 32'h0000_3039, 1, STS_MISSING, 0, 8));
    dir_rows.push_back(mk_row(CMD_REMOVE, 32'h7FFF_FFFF, 1, STS_OK, 1, 7));
    dir_rows.push_back(mk_row(CMD_SEARCH, 32'h7FFF_FFFF, 0, STS_OK, 0, 0));
    dir_rows.push_back(mk_row(CMD_REMOVE, 32'h5555_5555, 0, STS_OK, 0, 0));
    dir_rows.push_back(mk_row(CMD_REMOVE, 32'h8000_0000, 0, STS_OK, 0, 0));
    dir_rows.push_back(mk_row(CMD_SEARCH, 32'h8000_0000, 0, STS_OK, 0, 0));
    dir_rows.push_back(mk_row(CMD_REMOVE, 32'h0000_004D, 0, STS_OK, 0, 0));
    dir_rows.push_back(mk_row(CMD_CLEAR,  32'hAAAA_AAAA, 1, STS_OK, 0, 0));
    dir_rows.push_back(mk_row(CMD_SEARCH, 32'h0000_0000, 1, STS_EMPTY, 0, 0));
    dir_rows.push_back(mk_row(CMD_INSERT, 32'hAAAA_AAAA, 1, STS_OK, 0, 1));
    dir_rows.push_back(mk_row(CMD_REMOVE, 32'hAAAA_AAAA, 1, STS_OK, 0, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 5)       r.cmd = CMD_CLEAR;
      else if (pick < 40) r.cmd = CMD_INSERT;
      else if (pick < 70) r.cmd = CMD_SEARCH;
      else                r.cmd = CMD_REMOVE;
      case ($urandom_range(0, 3))
        0, 1: k = (list_count > 0) ? list_keys[$urandom_range(0, list_count - 1)] : $urandom;
        2: begin
          case ($urandom_range(0, 4))
            0: k = 32'h0000_0000;
            1: k = 32'hFFFF_FFFF;
            2: k = 32'h8000_0000;
            3: k = 32'h7FFF_FFFF;
            default: k = $urandom_range(0, 3);
          endcase
        end
        default: k = $urandom;
      endcase
      r.key = k;
      issue(r, 1'b0, none);
    end

    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d clear, %0d insert, %0d search, %0d remove; %0d results checked",
             cmd_seen[CMD_CLEAR], cmd_seen[CMD_INSERT], cmd_seen[CMD_SEARCH],
             cmd_seen[CMD_REMOVE], results_seen);
    $display("status mix: ok %0d, full %0d, empty %0d, not found %0d; %0d mismatches",
             status_seen[STS_OK], status_seen[STS_FULL], status_seen[STS_EMPTY],
             status_seen[STS_MISSING], mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/slt_pkg.sv
src/slt_dp.sv
src/slt_ctrl.sv
src/sequential_list_table_top.sv
tb/tb_top.sv
